@@ src/hrhp_pkg.sv @@
// hrhp_pkg: shared types, constants and name tables of the http response header parser
// depends on nothing; used by every other file of the block
package hrhp_pkg;

    localparam int DATA_W    = 8;
    localparam int ID_W      = 5;
    localparam int POS_W     = 10;
    localparam int NUM_NAMES = 13;
    localparam int LEN_W     = 6;
    localparam int TEXT_W    = 320;

    // default limits handed to the top level
    localparam int NAME_LIMIT_DEF   = 63;
    localparam int VALUE_LIMIT_DEF  = 255;
    localparam int REASON_LIMIT_DEF = 1023;
    localparam int TOKEN_LIMIT_DEF  = 8;

    // field ids
    localparam logic [ID_W-1:0] ID_PROTO    = 5'd0;
    localparam logic [ID_W-1:0] ID_STATUS   = 5'd1;
    localparam logic [ID_W-1:0] ID_REASON   = 5'd2;
    localparam logic [ID_W-1:0] ID_HDR_BASE = 5'd3;
    localparam logic [ID_W-1:0] ID_DONE     = 5'd16;

    // character codes
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CH_VT    = 8'h0B;
    localparam logic [DATA_W-1:0] CH_FF    = 8'h0C;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [6:0] {
        PH_PROTO  = 7'b0000001,
        PH_STATUS = 7'b0000010,
        PH_REASON = 7'b0000100,
        PH_NAME   = 7'b0001000,
        PH_VALUE  = 7'b0010000,
        PH_SKIP   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    // known header names, right-justified, first character highest
    localparam logic [TEXT_W-1:0] NAME_TEXT [NUM_NAMES] = '{
        "Access-Control-Allow-Origin",
        "Date",
        "Pragma",
        "Expires",
        "Cache-Control",
        "Access-Control-Allow-Credentials",
        "Content-Type",
        "Cross-Origin-Resource-Policy",
        "Content-Security-Policy-Report-Only",
        "Cross-Origin-Opener-Policy-Report-Only",
        "Report-To",
        "Server",
        "Content-Length"
    };

    localparam logic [LEN_W-1:0] NAME_LEN [NUM_NAMES] = '{
        6'd27, 6'd4, 6'd6, 6'd7, 6'd13, 6'd32, 6'd12, 6'd28, 6'd35, 6'd38, 6'd9, 6'd6, 6'd14
    };

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              start;
    } in_beat_t;

    typedef struct packed {
        logic [NUM_NAMES-1:0] keep;
        logic [NUM_NAMES-1:0] hit;
    } match_t;

    // character at position pos of known name k; zero past the end
    function automatic logic [DATA_W-1:0] name_char(input int k, input logic [LEN_W-1:0] pos);
        int sh;
        sh = int'(NAME_LEN[k]) - 1 - int'(pos);
        if (sh < 0)
            return '0;
        return NAME_TEXT[k][8*sh +: 8];
    endfunction

    function automatic logic is_ws(input logic [DATA_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

@@ src/hrhp_if.sv @@
// hrhp_if: valid/ready channel interfaces for input bytes and result fields
// depends on hrhp_pkg for widths
interface hrhp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [hrhp_pkg::DATA_W-1:0]  data_byte_in;
    logic                         message_start;

    modport source (output valid, data_byte_in, message_start, input ready);
    modport sink   (input valid, data_byte_in, message_start, output ready);
endinterface

interface hrhp_field_if;
    logic                         valid;
    logic                         ready;
    logic [hrhp_pkg::ID_W-1:0]    field_id;
    logic [hrhp_pkg::DATA_W-1:0]  value_byte;
    logic                         has_byte;
    logic                         field_end;

    modport source (output valid, field_id, value_byte, has_byte, field_end, input ready);
    modport sink   (input valid, field_id, value_byte, has_byte, field_end, output ready);
endinterface

@@ src/hrhp_in_stage.sv @@
// hrhp_in_stage: input register that takes one byte beat per cycle while it is empty or its beat is taken
// depends on hrhp_pkg and hrhp_if
module hrhp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    hrhp_byte_if.sink          bytes,
    input  logic               take,
    output logic               beat_valid,
    output hrhp_pkg::in_beat_t beat
);

    logic               valid_reg;
    hrhp_pkg::in_beat_t beat_reg;

    assign bytes.ready = !valid_reg || take;
    assign beat_valid  = valid_reg;
    assign beat        = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            beat_reg.data  <= bytes.data_byte_in;
            beat_reg.start <= bytes.message_start;
        end
    end

endmodule

@@ src/hrhp_name_match.sv @@
// hrhp_name_match: compares one name byte against the thirteen known header names
// depends on hrhp_pkg name tables
module hrhp_name_match
(
    input  logic [hrhp_pkg::POS_W-1:0]     pos,
    input  logic [hrhp_pkg::DATA_W-1:0]    data,
    input  logic [hrhp_pkg::NUM_NAMES-1:0] cand,
    output hrhp_pkg::match_t               match
);

    always_comb
    begin
        for (int k = 0; k < hrhp_pkg::NUM_NAMES; k++)
        begin
            // a candidate survives if the name is longer and the character agrees
            match.keep[k] = (pos < hrhp_pkg::POS_W'(hrhp_pkg::NAME_LEN[k])) &&
                (hrhp_pkg::name_char(k, pos[hrhp_pkg::LEN_W-1:0]) == data);
            // at the colon, a candidate hits when its length equals the name length
            match.hit[k]  = cand[k] && (hrhp_pkg::POS_W'(hrhp_pkg::NAME_LEN[k]) == pos);
        end
    end

endmodule

@@ src/hrhp_parser.sv @@
// hrhp_parser: parse state, per-byte decision and result register
// depends on hrhp_pkg, hrhp_if and hrhp_name_match
module hrhp_parser
#(
    parameter int NAME_LIMIT   = hrhp_pkg::NAME_LIMIT_DEF,
    parameter int VALUE_LIMIT  = hrhp_pkg::VALUE_LIMIT_DEF,
    parameter int REASON_LIMIT = hrhp_pkg::REASON_LIMIT_DEF,
    parameter int TOKEN_LIMIT  = hrhp_pkg::TOKEN_LIMIT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat_valid,
    input  hrhp_pkg::in_beat_t beat,
    output logic               take,
    hrhp_field_if.source       fields
);

    localparam logic [hrhp_pkg::POS_W-1:0] TOKEN_LIM  = hrhp_pkg::POS_W'(TOKEN_LIMIT);
    localparam logic [hrhp_pkg::POS_W-1:0] REASON_LIM = hrhp_pkg::POS_W'(REASON_LIMIT);
    localparam logic [hrhp_pkg::POS_W-1:0] VALUE_LIM  = hrhp_pkg::POS_W'(VALUE_LIMIT);
    localparam logic [hrhp_pkg::POS_W-1:0] NAME_LIM   = hrhp_pkg::POS_W'(NAME_LIMIT);

    hrhp_pkg::phase_t               phase_reg, phase_next, phase_cur;
    logic [hrhp_pkg::POS_W-1:0]     pos_reg, pos_next, pos_cur;
    logic [hrhp_pkg::NUM_NAMES-1:0] cand_reg, cand_next, cand_cur;
    logic                           skip_reg, skip_next, skip_cur;
    logic                           started_reg, started_next, started_cur;
    logic                           cr_reg, cr_next, cr_cur;

    logic                           out_valid_reg;
    logic [hrhp_pkg::ID_W-1:0]      id_reg;
    logic [hrhp_pkg::DATA_W-1:0]    byte_reg;
    logic                           has_reg;
    logic                           end_reg;

    logic                           emit;
    logic [hrhp_pkg::ID_W-1:0]      emit_id;
    logic [hrhp_pkg::DATA_W-1:0]    emit_byte;
    logic                           emit_has;
    logic                           emit_end;

    logic [hrhp_pkg::DATA_W-1:0]    b;
    logic                           ws;
    logic                           eol;
    logic [hrhp_pkg::ID_W-1:0]      cand_id;
    logic [hrhp_pkg::ID_W-1:0]      tok_id;
    logic [hrhp_pkg::POS_W-1:0]     limit;
    hrhp_pkg::match_t               match;

    assign take = beat_valid && (!out_valid_reg || fields.ready);

    assign b   = beat.data;
    assign ws  = hrhp_pkg::is_ws(b);
    assign eol = (b == hrhp_pkg::CH_CR) || (b == hrhp_pkg::CH_LF);

    // message start restarts the parser before this byte is looked at
    always_comb
    begin
        if (beat.start)
        begin
            phase_cur   = hrhp_pkg::PH_PROTO;
            pos_cur     = '0;
            cand_cur    = '1;
            skip_cur    = 1'b1;
            started_cur = 1'b0;
            cr_cur      = 1'b0;
        end
        else
        begin
            phase_cur   = phase_reg;
            pos_cur     = pos_reg;
            cand_cur    = cand_reg;
            skip_cur    = skip_reg;
            started_cur = started_reg;
            cr_cur      = cr_reg;
        end
    end

    hrhp_name_match u_name_match
    (
        .pos   (pos_cur),
        .data  (b),
        .cand  (cand_cur),
        .match (match)
    );

    // lowest surviving candidate gives the header field id
    always_comb
    begin
        cand_id = hrhp_pkg::ID_HDR_BASE;
        for (int k = hrhp_pkg::NUM_NAMES - 1; k >= 0; k--)
        begin
            if (cand_cur[k])
                cand_id = hrhp_pkg::ID_HDR_BASE + hrhp_pkg::ID_W'(k);
        end
    end

    always_comb
    begin
        phase_next   = phase_cur;
        pos_next     = pos_cur;
        cand_next    = cand_cur;
        skip_next    = skip_cur;
        started_next = started_cur;
        cr_next      = cr_cur;
        emit         = 1'b0;
        emit_id      = hrhp_pkg::ID_PROTO;
        emit_byte    = '0;
        emit_has     = 1'b0;
        emit_end     = 1'b0;
        tok_id       = hrhp_pkg::ID_PROTO;
        limit        = TOKEN_LIM;

        unique case (phase_cur) inside
            hrhp_pkg::PH_PROTO, hrhp_pkg::PH_STATUS, hrhp_pkg::PH_REASON, hrhp_pkg::PH_VALUE:
            begin
                unique case (phase_cur)
                    hrhp_pkg::PH_PROTO:
                    begin
                        tok_id = hrhp_pkg::ID_PROTO;
                        limit  = TOKEN_LIM;
                    end
                    hrhp_pkg::PH_STATUS:
                    begin
                        tok_id = hrhp_pkg::ID_STATUS;
                        limit  = TOKEN_LIM;
                    end
                    hrhp_pkg::PH_REASON:
                    begin
                        tok_id = hrhp_pkg::ID_REASON;
                        limit  = REASON_LIM;
                    end
                    default:
                    begin
                        tok_id = cand_id;
                        limit  = VALUE_LIM;
                    end
                endcase

                if (eol)
                begin
                    // field closes only if it carried a byte
                    emit         = started_cur;
                    emit_id      = tok_id;
                    emit_end     = 1'b1;
                    phase_next   = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::PH_NAME : hrhp_pkg::PH_SKIP;
                    pos_next     = '0;
                    cand_next    = '1;
                    skip_next    = 1'b1;
                    started_next = 1'b0;
                    cr_next      = 1'b0;
                end
                else if (ws && (phase_cur == hrhp_pkg::PH_PROTO ||
                                phase_cur == hrhp_pkg::PH_STATUS))
                begin
                    // whitespace ends a started protocol or status token
                    if (started_cur)
                    begin
                        emit         = 1'b1;
                        emit_id      = tok_id;
                        emit_end     = 1'b1;
                        phase_next   = (phase_cur == hrhp_pkg::PH_PROTO) ?
                                       hrhp_pkg::PH_STATUS : hrhp_pkg::PH_REASON;
                        pos_next     = '0;
                        cand_next    = '1;
                        skip_next    = 1'b1;
                        started_next = 1'b0;
                        cr_next      = 1'b0;
                    end
                end
                else if (!(ws && skip_cur))
                begin
                    skip_next    = 1'b0;
                    started_next = 1'b1;
                    if (pos_cur < limit)
                    begin
                        pos_next  = pos_cur + 1'b1;
                        emit      = 1'b1;
                        emit_id   = tok_id;
                        emit_byte = b;
                        emit_has  = 1'b1;
                    end
                end
            end
            hrhp_pkg::PH_NAME:
            begin
                if (b == hrhp_pkg::CH_LF)
                begin
                    // blank line ends the headers
                    phase_next   = (pos_cur == '0) ? hrhp_pkg::PH_DONE : hrhp_pkg::PH_NAME;
                    emit         = (pos_cur == '0);
                    emit_id      = hrhp_pkg::ID_DONE;
                    emit_end     = 1'b1;
                    pos_next     = '0;
                    cand_next    = '1;
                    skip_next    = 1'b1;
                    started_next = 1'b0;
                    cr_next      = 1'b0;
                end
                else if (cr_cur || (b == hrhp_pkg::CH_CR && pos_cur != '0))
                begin
                    phase_next   = hrhp_pkg::PH_SKIP;
                    pos_next     = '0;
                    cand_next    = '1;
                    skip_next    = 1'b1;
                    started_next = 1'b0;
                    cr_next      = 1'b0;
                end
                else if (b == hrhp_pkg::CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else if (b == hrhp_pkg::CH_COLON)
                begin
                    pos_next     = '0;
                    skip_next    = 1'b1;
                    started_next = 1'b0;
                    cr_next      = 1'b0;
                    if (pos_cur == '0 || pos_cur > NAME_LIM || match.hit == '0)
                    begin
                        phase_next = hrhp_pkg::PH_SKIP;
                        cand_next  = '1;
                    end
                    else
                    begin
                        phase_next = hrhp_pkg::PH_VALUE;
                        cand_next  = match.hit;
                    end
                end
                else
                begin
                    cand_next = cand_cur & match.keep;
                    if (pos_cur != '1)
                        pos_next = pos_cur + 1'b1;
                end
            end
            hrhp_pkg::PH_SKIP:
            begin
                if (b == hrhp_pkg::CH_LF)
                begin
                    phase_next   = hrhp_pkg::PH_NAME;
                    pos_next     = '0;
                    cand_next    = '1;
                    skip_next    = 1'b1;
                    started_next = 1'b0;
                    cr_next      = 1'b0;
                end
            end
            default:
            begin
                // done: bytes dropped until the next message start
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hrhp_pkg::PH_PROTO;
            pos_reg       <= '0;
            cand_reg      <= '1;
            skip_reg      <= 1'b1;
            started_reg   <= 1'b0;
            cr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                cand_reg      <= cand_next;
                skip_reg      <= skip_next;
                started_reg   <= started_next;
                cr_reg        <= cr_next;
                out_valid_reg <= emit;
            end
            else if (fields.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            id_reg   <= emit_id;
            byte_reg <= emit_byte;
            has_reg  <= emit_has;
            end_reg  <= emit_end;
        end
    end

    assign fields.valid      = out_valid_reg;
    assign fields.field_id   = id_reg;
    assign fields.value_byte = byte_reg;
    assign fields.has_byte   = has_reg;
    assign fields.field_end  = end_reg;

    a_byte_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (has_reg != end_reg))
        else $error("result carries both or neither of byte and end");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_reg) |-> (byte_reg == '0))
        else $error("value byte not zero without a byte");

    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && emit_id == hrhp_pkg::ID_DONE) |=> (phase_reg == hrhp_pkg::PH_DONE))
        else $error("headers done emitted but parser not in done phase");

    a_value_has_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hrhp_pkg::PH_VALUE) |-> (cand_reg != '0))
        else $error("header value phase without a matched name");

endmodule

@@ src/http_response_header_parser_top.sv @@
// http_response_header_parser_top: top level of the http response header parser
// depends on hrhp_pkg, hrhp_if, hrhp_in_stage, hrhp_parser and hrhp_name_match
//
// usage
//   bytes  : one beat per response byte; message_start marks the first byte of a
//            new response and restarts the parser on that very byte
//   fields : zero or one beat per input byte; field_id 0 protocol, 1 status,
//            2 reason, 3..15 known headers, 16 headers done; has_byte flags a
//            value byte, field_end closes a field
// pipeline
//   a byte waits in the input register; its result is then written into the result
//   register, which presents it on fields
// throughput
//   one byte per cycle sustained while fields is ready; the parse state updates
//   once per byte in a single pass of logic between the input and result registers
// reset
//   rst_n clears both registers' valid flags and puts the parser in the
//   protocol phase with all header names as candidates
// stall
//   while fields is stalled the result register holds; one more byte waits in
//   the input register, then bytes.ready drops until the result is taken
module http_response_header_parser_top
#(
    parameter int NAME_LIMIT   = hrhp_pkg::NAME_LIMIT_DEF,
    parameter int VALUE_LIMIT  = hrhp_pkg::VALUE_LIMIT_DEF,
    parameter int REASON_LIMIT = hrhp_pkg::REASON_LIMIT_DEF,
    parameter int TOKEN_LIMIT  = hrhp_pkg::TOKEN_LIMIT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    hrhp_byte_if.sink    bytes,
    hrhp_field_if.source fields
);

    // handshake between input register and parse stage
    logic               take;
    logic               beat_valid;
    hrhp_pkg::in_beat_t beat;

    hrhp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // parse state, name matching and result register
    hrhp_parser
    #(
        .NAME_LIMIT   (NAME_LIMIT),
        .VALUE_LIMIT  (VALUE_LIMIT),
        .REASON_LIMIT (REASON_LIMIT),
        .TOKEN_LIMIT  (TOKEN_LIMIT)
    )
    u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take),
        .fields     (fields)
    );

endmodule
